FILE: rtl/core/assert_macros.svh
// Assertion helpers used by cssp_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define ASSERT_NXT(lbl, ck, rstn, ante, cons)
`endif

`endif

FILE: rtl/core/cssp_pkg.sv
`timescale 1ns / 1ps

package cssp_pkg;

	localparam int COORD_W = 16;
	localparam int MAX_STEPS = 16;

	// largest L with 2^L <= MAX_STEPS
	localparam int STEPS_LOG2_MAX = $clog2(MAX_STEPS + 1) - 1;
	localparam int CNT_W = (STEPS_LOG2_MAX > 0) ? STEPS_LOG2_MAX : 1;

	localparam int COEF_W = COORD_W + 5;
	localparam int ACC_W = COORD_W + 7 + 3 * STEPS_LOG2_MAX;
	localparam int M_W = COORD_W + 7;

	// floor(u / 3) as (u * RCP) >> RCP_K, exact for u < 2^M_W
	localparam int RCP_K = M_W + 2;
	localparam logic [RCP_K-1:0] RCP = RCP_K'(((64'd1 << RCP_K) + 64'd2) / 64'd3);
	localparam int PROD_W = M_W + RCP_K;
	localparam logic [M_W-1:0] DIV3_BIAS = M_W'(3) << (COORD_W + 4);
	localparam logic [M_W-1:0] DIV3_OFFS = M_W'(1) << (COORD_W + 4);

	localparam logic signed [M_W-1:0] SAT_HI = M_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
	localparam logic signed [M_W-1:0] SAT_LO = M_W'(-(64'sd1 <<< (COORD_W - 1)));

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_USE_BSPLINE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS_LOG2 = 2'd1;
	localparam logic [2:0] STEPS_LOG2_RESET = 3'd4;
	localparam logic [1:0] HELD_FULL = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] sample_x;
		logic signed [COORD_W-1:0] sample_z;
		logic segment_end;
	} sample_t;

	typedef struct packed {
		logic shift;
		logic load;
		logic init;
		logic step;
		logic last;
		logic bspline;
		logic [2:0] steps;
	} cmd_t;

	typedef struct packed {
		logic adv;
	} status_t;

endpackage

FILE: rtl/core/cubic_spline_segment_sampler.sv
// Cubic spline segment sampler.
// Control points arrive as requests on point_valid/point_ready (signed Q8.8
// x and z). The first three points only fill the window. Each later point
// closes a segment and yields 2^steps_log2 samples (capped at 16) on
// sample_valid/sample_ready, in order of u, with segment_end on the last.
// Configuration goes over cfg_valid/cfg_ready: index 0 is use_bspline
// (0 Catmull-Rom, 1 uniform B-spline), index 1 is steps_log2. Write only
// while no segment is in flight; cfg_ready is always high.
// After a segment point is taken, the sequencer passes ST_INIT, then steps
// in ST_RUN once per sample; a window-fill point leaves it in ST_IDLE. The
// rate is set by the single forward-difference engine per coordinate,
// which produces one sample per cycle unless sample_ready stalls it.
// A stalled sample_ready freezes the 3-stage output pipeline and the
// difference engine; nothing is dropped. The next point can be taken as
// soon as the last sample has entered the pipeline.
// Reset clears the window and point count, selects Catmull-Rom and sets
// steps_log2 to 4.
`timescale 1ns / 1ps

module cubic_spline_segment_sampler (
	input logic clk,
	input logic arst_n,
	input logic point_valid,
	output logic point_ready,
	input cssp_pkg::point_t point,
	output logic sample_valid,
	input logic sample_ready,
	output cssp_pkg::sample_t sample,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [cssp_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [cssp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cssp_pkg::*;

	cmd_t cmd;
	status_t status;

	cssp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_ready(point_ready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.status(status)
	);

	cssp_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.point(point),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample)
	);

endmodule

FILE: rtl/core/cssp_coord.sv
`timescale 1ns / 1ps

module cssp_coord (
	input logic clk,
	input cssp_pkg::cmd_t cmd,
	input logic adv,
	input logic signed [cssp_pkg::COORD_W-1:0] p0,
	input logic signed [cssp_pkg::COORD_W-1:0] p1,
	input logic signed [cssp_pkg::COORD_W-1:0] p2,
	input logic signed [cssp_pkg::COORD_W-1:0] p3,
	output logic signed [cssp_pkg::COORD_W-1:0] result
);
	import cssp_pkg::*;

	logic signed [COEF_W-1:0] e0, e1, e2, e3, t_bs, dc;
	logic signed [COEF_W-1:0] a_n, b_n, c_n, d_n;
	logic signed [COEF_W-1:0] a_q, b_q, c_q, d_q;
	logic signed [ACC_W-1:0] ax, bx, cx, dx, a6;
	logic signed [ACC_W-1:0] acc_q, d1_q, d2_q, d3_q;
	logic signed [ACC_W-1:0] bias, rsum, rsh;
	logic [4:0] s2, s3;
	logic signed [M_W-1:0] m_s1, m_s2, quo, qsel;
	logic [M_W-1:0] u_n;
	logic [PROD_W-1:0] prod_s2;
	logic signed [COORD_W-1:0] sat_n, res_s3;

	assign e0 = COEF_W'(p0);
	assign e1 = COEF_W'(p1);
	assign e2 = COEF_W'(p2);
	assign e3 = COEF_W'(p3);
	assign t_bs = e0 - (e1 <<< 1) + e2;
	assign dc = e2 - e0;

	// cubic coefficients of the segment, scaled to integers
	always_comb begin
		a_n = e3 - e0 + ((e1 - e2) <<< 1) + (e1 - e2);
		if (cmd.bspline) begin
			b_n = t_bs + (t_bs <<< 1);
			c_n = dc + (dc <<< 1);
			d_n = e0 + (e1 <<< 2) + e2;
		end else begin
			b_n = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
			c_n = dc;
			d_n = e1 <<< 1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= a_n;
			b_q <= b_n;
			c_q <= c_n;
			d_q <= d_n;
		end
	end

	assign s2 = {1'b0, cmd.steps, 1'b0};
	assign s3 = s2 + {2'b00, cmd.steps};
	assign ax = ACC_W'(a_q);
	assign bx = ACC_W'(b_q);
	assign cx = ACC_W'(c_q);
	assign dx = ACC_W'(d_q);
	assign a6 = (ax <<< 2) + (ax <<< 1);

	// forward differences of the numerator polynomial in j
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			acc_q <= dx <<< s3;
			d1_q <= ax + (bx <<< cmd.steps) + (cx <<< s2);
			d2_q <= a6 + ((bx <<< cmd.steps) <<< 1);
			d3_q <= a6;
		end else if (cmd.step && adv) begin
			acc_q <= acc_q + d1_q;
			d1_q <= d1_q + d2_q;
			d2_q <= d2_q + d3_q;
		end
	end

	// round half up: add half the denominator, drop the power-of-two part
	assign bias = (cmd.bspline ? ACC_W'(3) : ACC_W'(1)) <<< s3;
	assign rsum = acc_q + bias;
	assign rsh = rsum >>> (s3 + 5'd1);
	assign u_n = M_W'(m_s1) + DIV3_BIAS;
	assign quo = M_W'(prod_s2 >> RCP_K) - DIV3_OFFS;
	assign qsel = cmd.bspline ? quo : m_s2;

	always_comb begin
		if (qsel > SAT_HI) begin
			sat_n = SAT_HI[COORD_W-1:0];
		end else if (qsel < SAT_LO) begin
			sat_n = SAT_LO[COORD_W-1:0];
		end else begin
			sat_n = qsel[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1 <= rsh[M_W-1:0];
			m_s2 <= m_s1;
			prod_s2 <= PROD_W'(u_n) * PROD_W'(RCP);
			res_s3 <= sat_n;
		end
	end

	assign result = res_s3;

endmodule

FILE: rtl/core/cssp_datapath.sv
`timescale 1ns / 1ps

module cssp_datapath (
	input logic clk,
	input logic arst_n,
	input cssp_pkg::cmd_t cmd,
	output cssp_pkg::status_t status,
	input cssp_pkg::point_t point,
	output logic sample_valid,
	input logic sample_ready,
	output cssp_pkg::sample_t sample
);
	import cssp_pkg::*;

	logic signed [COORD_W-1:0] wx_q [3];
	logic signed [COORD_W-1:0] wz_q [3];
	logic vld_s1, vld_s2, vld_s3;
	logic last_s1, last_s2, last_s3;
	logic adv;
	logic signed [COORD_W-1:0] rx, rz;

	// hold the whole pipeline while the output register is full and stalled
	assign adv = !vld_s3 || sample_ready;
	assign status.adv = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				wx_q[i] <= '0;
				wz_q[i] <= '0;
			end
		end else if (cmd.shift) begin
			wx_q[0] <= wx_q[1];
			wx_q[1] <= wx_q[2];
			wx_q[2] <= point.point_x;
			wz_q[0] <= wz_q[1];
			wz_q[1] <= wz_q[2];
			wz_q[2] <= point.point_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= cmd.step;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= cmd.last;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
		end
	end

	cssp_coord u_coord_x (
		.clk(clk),
		.cmd(cmd),
		.adv(adv),
		.p0(wx_q[0]),
		.p1(wx_q[1]),
		.p2(wx_q[2]),
		.p3(point.point_x),
		.result(rx)
	);

	cssp_coord u_coord_z (
		.clk(clk),
		.cmd(cmd),
		.adv(adv),
		.p0(wz_q[0]),
		.p1(wz_q[1]),
		.p2(wz_q[2]),
		.p3(point.point_z),
		.result(rz)
	);

	assign sample_valid = vld_s3;
	assign sample.sample_x = rx;
	assign sample.sample_z = rz;
	assign sample.segment_end = last_s3;

endmodule

FILE: rtl/core/cssp_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cssp_ctrl (
	input logic clk,
	input logic arst_n,
	input logic point_valid,
	output logic point_ready,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [cssp_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [cssp_pkg::CFG_DATA_W-1:0] cfg_data,
	output cssp_pkg::cmd_t cmd,
	input cssp_pkg::status_t status
);
	import cssp_pkg::*;

	state_t state_q, state_n;
	logic [1:0] held_q;
	logic [CNT_W-1:0] cnt_q, cnt_last;
	logic bspline_q;
	logic [2:0] steps_q, steps_eff;

	assign steps_eff = (steps_q > 3'(STEPS_LOG2_MAX)) ? 3'(STEPS_LOG2_MAX) : steps_q;
	assign cnt_last = CNT_W'((32'd1 << steps_eff) - 32'd1);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q <= '0;
			cnt_q <= '0;
			bspline_q <= 1'b0;
			steps_q <= STEPS_LOG2_RESET;
		end else begin
			state_q <= state_n;
			if (cmd.shift && held_q != HELD_FULL) begin
				held_q <= held_q + 2'd1;
			end
			if (cmd.init) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_USE_BSPLINE: bspline_q <= cfg_data[0];
					REG_STEPS_LOG2: steps_q <= cfg_data[2:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		state_n = state_q;
		point_ready = 1'b0;
		cmd = '0;
		cmd.bspline = bspline_q;
		cmd.steps = steps_eff;
		cmd.last = (cnt_q == cnt_last);
		case (state_q)
			ST_IDLE: begin
				point_ready = 1'b1;
				if (point_valid) begin
					cmd.shift = 1'b1;
					// a full window plus the new point spans one segment
					if (held_q == HELD_FULL) begin
						cmd.load = 1'b1;
						state_n = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_n = ST_RUN;
			end
			ST_RUN: begin
				if (status.adv) begin
					cmd.step = 1'b1;
					if (cmd.last) begin
						state_n = ST_IDLE;
					end
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	`ASSERT_IMP(a_load_full, clk, arst_n, cmd.load, held_q == HELD_FULL)
	`ASSERT_NXT(a_last_idle, clk, arst_n, cmd.step && cmd.last, state_q == ST_IDLE)
	`ASSERT_IMP(a_cnt_range, clk, arst_n, state_q == ST_RUN, cnt_q <= cnt_last)
	`ASSERT_NXT(a_init_clear, clk, arst_n, state_q == ST_INIT, cnt_q == '0)

endmodule
